FILE: hw/rtl/sia_pkg.sv
// Shared types, opcodes and saturation helpers of the saturating integer ALU.
`timescale 1ns / 1ps
`default_nettype none
package sia_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth   = 4;
  localparam int unsigned DivSteps  = DataWidth;

  typedef enum logic [OpWidth-1:0] {
    OpSadd    = 4'd0,
    OpSsub    = 4'd1,
    OpUadd    = 4'd2,
    OpUsub    = 4'd3,
    OpUaddS   = 4'd4,
    OpUsubS   = 4'd5,
    OpAbsDiff = 4'd6,
    OpClamp   = 4'd7,
    OpUmin    = 4'd8,
    OpUdiv    = 4'd9,
    OpUrem    = 4'd10,
    OpUmul    = 4'd11
  } sia_op_e;

  localparam logic RegClampLow  = 1'b0;
  localparam logic RegClampHigh = 1'b1;

  localparam logic [DataWidth-1:0] SMax    = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] SMinSat = {1'b1, {(DataWidth-2){1'b0}}, 1'b1};
  localparam logic [DataWidth-1:0] UMax    = {DataWidth{1'b1}};
  localparam logic [DataWidth-1:0] Zero    = {DataWidth{1'b0}};

  // One item in flight through the divider pipeline.
  typedef struct packed {
    logic [OpWidth-1:0]   op;
    logic [DataWidth-1:0] res;
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] dvs;
  } sia_slot_t;

  function automatic logic [DataWidth-1:0] sat_uadd(input logic [DataWidth-1:0] a,
                                                    input logic [DataWidth-1:0] b);
    logic [DataWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DataWidth] ? UMax : s[DataWidth-1:0];
  endfunction

  function automatic logic [DataWidth-1:0] sat_usub(input logic [DataWidth-1:0] a,
                                                    input logic [DataWidth-1:0] b);
    logic [DataWidth:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[DataWidth] ? Zero : d[DataWidth-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sia_exec.sv
// First pipeline stage: arithmetic, compare and clamp operations, multiply, divider setup.
`timescale 1ns / 1ps
`default_nettype none
module sia_exec import sia_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 up_valid_i,
  input  wire logic [OpWidth-1:0]   opcode_i,
  input  wire logic [DataWidth-1:0] operand_a_i,
  input  wire logic [DataWidth-1:0] operand_b_i,
  input  wire logic [DataWidth-1:0] clamp_low_i,
  input  wire logic [DataWidth-1:0] clamp_high_i,
  input  wire logic                 dn_ready_i,
  output logic                      ready_o,
  output logic                      valid_o,
  output sia_slot_t                 slot_o
);

  logic                 valid_q;
  sia_slot_t            slot_q, slot_d;
  logic [DataWidth-1:0] a, b, res, sum, dif, negb, prod;
  logic                 s_ovf, d_ovf;

  assign a    = operand_a_i;
  assign b    = operand_b_i;
  assign sum  = a + b;
  assign dif  = a - b;
  assign negb = Zero - b;
  assign prod = a * b;
  assign s_ovf = ~(a[DataWidth-1] ^ b[DataWidth-1]) & (sum[DataWidth-1] ^ a[DataWidth-1]);
  assign d_ovf = (a[DataWidth-1] ^ b[DataWidth-1]) & (dif[DataWidth-1] ^ a[DataWidth-1]);

  always_comb begin
    case (opcode_i)
      OpSadd:    res = s_ovf ? (a[DataWidth-1] ? SMinSat : SMax) : sum;
      OpSsub:    res = d_ovf ? (a[DataWidth-1] ? SMinSat : SMax) : dif;
      OpUadd:    res = sat_uadd(a, b);
      OpUsub:    res = sat_usub(a, b);
      OpUaddS:   res = b[DataWidth-1] ? sat_usub(a, negb) : sat_uadd(a, b);
      OpUsubS:   res = b[DataWidth-1] ? sat_uadd(a, negb) : sat_usub(a, b);
      OpAbsDiff: res = ($signed(a) < $signed(b)) ? (b - a) : dif;
      OpClamp: begin
        if ($signed(a) < $signed(clamp_low_i)) res = clamp_low_i;
        else if ($signed(clamp_high_i) < $signed(a)) res = clamp_high_i;
        else res = a;
      end
      OpUmin:    res = (a > b) ? b : a;
      OpUmul:    res = prod;
      default:   res = Zero;
    endcase
  end

  always_comb begin
    slot_d.op  = opcode_i;
    slot_d.res = res;
    slot_d.rem = Zero;
    slot_d.quo = a;
    slot_d.dvs = b;
  end

  assign ready_o = ~valid_q | dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && up_valid_i) begin
      slot_q <= slot_d;
    end
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sia_div_stage.sv
// One restoring-division step as a pipeline stage; other fields pass along.
`timescale 1ns / 1ps
`default_nettype none
module sia_div_stage import sia_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       up_valid_i,
  input  wire sia_slot_t  up_slot_i,
  input  wire logic       dn_ready_i,
  output logic            ready_o,
  output logic            valid_o,
  output sia_slot_t       slot_o
);

  logic               valid_q;
  sia_slot_t          slot_q, slot_d;
  logic [DataWidth:0]   trial;
  logic [DataWidth+1:0] diff;
  logic                 ge;

  // Shift in the next dividend bit, subtract when the divisor fits.
  assign trial = {up_slot_i.rem, up_slot_i.quo[DataWidth-1]};
  assign diff  = {1'b0, trial} - {2'b00, up_slot_i.dvs};
  assign ge    = ~diff[DataWidth+1];

  always_comb begin
    slot_d     = up_slot_i;
    slot_d.rem = ge ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
    slot_d.quo = {up_slot_i.quo[DataWidth-2:0], ge};
  end

  assign ready_o = ~valid_q | dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && up_valid_i) begin
      slot_q <= slot_d;
    end
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;

endmodule
`default_nettype wire

FILE: hw/rtl/saturating_integer_alu.sv
// Top level of the pipelined saturating integer ALU.
// Pipeline: 1 execute stage, 32 divider stages of one quotient bit each,
//   1 output register; one transaction per cycle unless the output stalls.
// Every op walks the full pipeline.
// Reset: asynchronous active low; clears all stage valids, loads clamp_low
//   with -2147483647 and clamp_high with 2147483647.
`timescale 1ns / 1ps
`default_nettype none
module saturating_integer_alu import sia_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_index_i,
  input  wire logic [DataWidth-1:0] cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [OpWidth-1:0]   opcode_i,
  input  wire logic [DataWidth-1:0] operand_a_i,
  input  wire logic [DataWidth-1:0] operand_b_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DataWidth-1:0]      result_o
);

  logic [DataWidth-1:0] clamp_low_q, clamp_high_q;

  // Clamp bounds; the user must write them only while the pipeline is empty, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_low_q  <= SMinSat;
      clamp_high_q <= SMax;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegClampLow) clamp_low_q <= cfg_data_i;
      if (cfg_index_i == RegClampHigh) clamp_high_q <= cfg_data_i;
    end
  end

  // Stage 0 is the execute stage, stages 1..DivSteps are divider steps.
  logic      stg_valid [DivSteps+1];
  sia_slot_t stg_slot  [DivSteps+1];
  logic      stg_ready [DivSteps+1];
  logic      out_ready;

  sia_exec u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (in_valid_i),
    .opcode_i     (opcode_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .clamp_low_i  (clamp_low_q),
    .clamp_high_i (clamp_high_q),
    .dn_ready_i   (stg_ready[1]),
    .ready_o      (stg_ready[0]),
    .valid_o      (stg_valid[0]),
    .slot_o       (stg_slot[0])
  );

  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    logic dn_ready;
    // Hold a stage only when the one below is full and held too.
    if (k == DivSteps) begin : g_last
      assign dn_ready = out_ready;
    end else begin : g_mid
      assign dn_ready = stg_ready[k+1];
    end

    sia_div_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (stg_valid[k-1]),
      .up_slot_i  (stg_slot[k-1]),
      .dn_ready_i (dn_ready),
      .ready_o    (stg_ready[k]),
      .valid_o    (stg_valid[k]),
      .slot_o     (stg_slot[k])
    );
  end

  assign in_stall_o = ~stg_ready[0];

  // Output register: pick the divider result for divide and remainder, or zero when the divisor is zero.
  logic                 out_valid_q;
  logic [DataWidth-1:0] result_q, result_d;
  sia_slot_t            fin;

  assign fin = stg_slot[DivSteps];

  always_comb begin
    case (fin.op)
      OpUdiv:  result_d = (fin.dvs == Zero) ? Zero : fin.quo;
      OpUrem:  result_d = (fin.dvs == Zero) ? Zero : fin.rem;
      default: result_d = fin.res;
    endcase
  end

  assign out_ready = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= stg_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && stg_valid[DivSteps]) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sia_checker.sv
// Port-level checker for the saturating integer ALU, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sia_checker import sia_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [DataWidth-1:0] result_o
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_o))
    else $error("result changed while stalled");

  a_no_input_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

bind saturating_integer_alu sia_checker u_sia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .result_o    (result_o)
);
`default_nettype wire

FILE: dv/alu_checker.sv
// Predicts and checks the results of the saturating integer ALU.
`timescale 1ns / 1ps
`default_nettype none
module alu_checker import sia_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_index_i,
  input  wire logic [DataWidth-1:0] cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire logic [OpWidth-1:0]   opcode_i,
  input  wire logic [DataWidth-1:0] operand_a_i,
  input  wire logic [DataWidth-1:0] operand_b_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire logic [DataWidth-1:0] result_i,
  output int                        errors_o,
  output int                        pending_o
);
  logic [DataWidth-1:0] lo_q, hi_q;
  logic [DataWidth-1:0] results_q[$];

  function automatic logic [DataWidth-1:0] alu_result(
      input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] a,
      input logic [DataWidth-1:0] b);
    logic [DataWidth:0] w;
    logic signed [DataWidth:0] s;
    logic [DataWidth-1:0] nb;
    nb = -b;
    case (op)
      OpSadd: begin
        s = $signed({a[DataWidth-1], a}) + $signed({b[DataWidth-1], b});
        return (s[DataWidth] != s[DataWidth-1]) ? (s[DataWidth] ? SMinSat : SMax)
                                                : s[DataWidth-1:0];
      end
      OpSsub: begin
        s = $signed({a[DataWidth-1], a}) - $signed({b[DataWidth-1], b});
        return (s[DataWidth] != s[DataWidth-1]) ? (s[DataWidth] ? SMinSat : SMax)
                                                : s[DataWidth-1:0];
      end
      OpUadd: begin
        w = {1'b0, a} + {1'b0, b};
        return w[DataWidth] ? UMax : w[DataWidth-1:0];
      end
      OpUsub:  return (a < b) ? Zero : a - b;
      OpUaddS: return b[DataWidth-1] ? ((a < nb) ? Zero : a - nb)
                                     : ((({1'b0, a} + b) >> DataWidth) != 0 ? UMax : a + b);
      OpUsubS: return b[DataWidth-1] ? ((({1'b0, a} + nb) >> DataWidth) != 0 ? UMax : a + nb)
                                     : ((a < b) ? Zero : a - b);
      OpAbsDiff: return ($signed(a) < $signed(b)) ? b - a : a - b;
      OpClamp: begin
        if ($signed(a) < $signed(lo_q)) return lo_q;
        if ($signed(hi_q) < $signed(a)) return hi_q;
        return a;
      end
      OpUmin: return (a > b) ? b : a;
      OpUdiv: return (b == 0) ? Zero : a / b;
      OpUrem: return (b == 0) ? Zero : a % b;
      OpUmul: return a * b;
      default: return Zero;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors_o++;
  endtask

  initial errors_o = 0;
  assign pending_o = results_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= SMinSat;
      hi_q <= SMax;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_q.size() == 0) report_mismatch($sformatf("extra result %h", result_i));
        else begin
          if (result_i !== results_q[0])
            report_mismatch($sformatf("result %h, predicted %h", result_i, results_q[0]));
          void'(results_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i)
        results_q.push_back(alu_result(opcode_i, operand_a_i, operand_b_i));
      if (cfg_we_i) begin
        if (cfg_index_i == RegClampLow) lo_q <= cfg_data_i;
        else hi_q <= cfg_data_i;
      end
    end
  end
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Stimulus and verdict for the saturating integer ALU testbench.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import sia_pkg::*;

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [DataWidth-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [OpWidth-1:0] opcode;
  logic [DataWidth-1:0] operand_a, operand_b, result;
  int errors, pending;
  bit long_hold;

  saturating_integer_alu uut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .operand_a_i(operand_a), .operand_b_i(operand_b),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .result_o(result)
  );

  alu_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .operand_a_i(operand_a), .operand_b_i(operand_b),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .result_i(result),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Pick an operand with frequent corner values.
  function automatic logic [DataWidth-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return Zero;
      1: return UMax;
      2: return SMax;
      3: return SMinSat;
      4: return {1'b1, {(DataWidth-1){1'b0}}};
      5: return $urandom_range(0, 15);
      6: return -$urandom_range(1, 15);
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction, hold it until accepted, then, for a nonzero gap, drop valid for that gap.
  task automatic send_op(input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] a,
                         input logic [DataWidth-1:0] b, input int gap);
    opcode <= op;
    operand_a <= a;
    operand_b <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait out all predictions plus the pipeline depth, then write a register.
  task automatic write_reg(input logic idx, input logic [DataWidth-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int draw_gap(input int mode);
    return (mode == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // Receiver: random stall per cycle count, plus one long hold-off on request.
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (out_stall) begin
        out_stall <= 1'b0;
      end else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (wait_cycles > 0 && $urandom_range(0, 1)) begin
          out_stall <= 1'b1;
          repeat (wait_cycles - 1) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int mode;
    logic [DataWidth-1:0] lim_lo[4], lim_hi[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegClampLow;
    cfg_data = '0;
    opcode = '0;
    operand_a = '0;
    operand_b = '0;
    long_hold = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every opcode at the corners, with reset bounds.
    for (int op = 0; op < 16; op++) begin
      send_op(OpWidth'(op), SMax, 32'd1, 0);
      send_op(OpWidth'(op), SMinSat - 1, SMinSat, 1);
    end
    send_op(OpUdiv, UMax, Zero, 0);
    send_op(OpUrem, UMax, Zero, 0);
    send_op(OpClamp, {1'b1, {(DataWidth-1){1'b0}}}, Zero, 0);
    send_op(OpUaddS, 32'd5, UMax, 0);
    send_op(OpUsubS, UMax, UMax, 0);

    // Phases with different bounds, crossed ones among them.
    lim_lo = '{{1'b1, {(DataWidth-1){1'b0}}}, -32'd100, 32'd50, SMax};
    lim_hi = '{SMax, 32'd100, -32'd50, {1'b1, {(DataWidth-1){1'b0}}}};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(RegClampLow, ph < 4 ? lim_lo[ph] : $urandom);
      write_reg(RegClampHigh, ph < 4 ? lim_hi[ph] : $urandom);
      if (ph == 2) long_hold = 1'b1;
      mode = $urandom_range(0, 1);
      for (int i = 0; i < 340; i++) begin
        if (i % 100 == 0) mode = $urandom_range(0, 2);
        send_op(OpWidth'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 11)),
                pick_operand(), pick_operand(), draw_gap(mode));
        if (i == 170) begin
          in_valid <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
